// ===== design/running_average_background_subtract_assert.svh =====
// Assertion shorthands for the background subtractor.
// Both expect clk and rst_n to be visible where they are used.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define RABS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rabs: invariant violated");

// Consequent must hold in the same cycle as the antecedent
`define RABS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rabs: implication violated");

`endif

// ===== design/rabs_pkg.sv =====
package rabs_pkg;

    // Input item codes
    typedef enum logic [1:0] {
        MODE_PIXEL = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_LEARN = 2'd2
    } rabs_mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LEARN_RATE     = 2'd0,
        REG_TRACK_DARK     = 2'd1,
        REG_RELEARN_PERIOD = 2'd2
    } rabs_reg_t;

    // Register reset values
    localparam logic [9:0]  LEARN_RATE_RST = 10'd400;
    localparam logic [14:0] PERIOD_RST     = 15'd2200;

    // Saturation limit of the millisecond counter
    localparam logic [14:0] ELAPSED_MAX = 15'h7FFF;

    // Update weights are in thousandths
    localparam logic [9:0]  RATE_FULL  = 10'd1000;
    localparam logic [25:0] ROUND_HALF = 26'd500;

    // Blend numerator is below 2^26; divide by 1000 via floor(2^36/1000)
    localparam int          NUM_W          = 26;
    localparam int          RECIP1000_W    = 27;
    localparam int          DIV1000_SHIFT  = 36;
    localparam logic [26:0] DIV1000_MUL    = 27'd68719476;

    // round(bg/257) = floor((bg+128)/257), via ceil(2^24/257)
    localparam int          DIV257_SHIFT = 24;
    localparam logic [15:0] DIV257_MUL   = 16'd65281;
    localparam logic [16:0] BG8_BIAS     = 17'd128;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pixel;
        logic       frame_start;
    } rabs_in_t;

    typedef struct packed {
        logic [7:0] difference;
        logic       learned_frame;
    } rabs_out_t;

    typedef struct packed {
        logic [9:0]  learn_rate;
        logic        track_dark;
        logic [14:0] relearn_period_ms;
    } rabs_cfg_t;

    // Pixel handed from the frame control to the update pipeline
    typedef struct packed {
        logic       valid;
        logic       learn;
        logic [7:0] pixel;
    } rabs_issue_t;

    // Pipeline status seen by the frame control
    typedef struct packed {
        logic space;
        logic conflict;
    } rabs_pipe_status_t;

endpackage

// ===== design/rabs_stream_if.sv =====
interface rabs_stream_if #(
    parameter type payload_t = rabs_pkg::rabs_in_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/running_average_background_subtract.sv =====
// Running-average background subtractor: one item (pixel, millisecond tick or
// learn request) is taken per clock while the pipeline has space and no pixel is
// held back, and each pixel's result passes through a four-stage read-modify-write
// pipeline around a single background memory of FRAME_PIXELS 16-bit words (read
// port at issue, write port at the end of stage three), with an output register
// behind it; items keep being taken while a result waits, until the pipeline is
// full. A pixel is held back while the word at its own position is still being
// updated in the pipeline, which only happens in frames shorter than four pixels.
// Ticks, requests and pixels before the first learn frame give no result. The
// memory has no clearing pass: a word is undefined until a learn frame has covered
// its position.
`include "running_average_background_subtract_assert.svh"

module running_average_background_subtract #(
    parameter int FRAME_PIXELS = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    rabs_stream_if.sink   stream,
    rabs_stream_if.source result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    rabs_pkg::rabs_cfg_t         cfg;
    rabs_pkg::rabs_issue_t       issue;
    rabs_pkg::rabs_pipe_status_t status;
    logic [ADDR_W-1:0]           slot_pos;
    logic                        pixel_fire;

    rabs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rabs_ctrl #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .cfg      (cfg),
        .status   (status),
        .issue    (issue),
        .slot_pos (slot_pos)
    );

    rabs_datapath #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .ADDR_W       (ADDR_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .issue    (issue),
        .slot_pos (slot_pos),
        .status   (status),
        .result   (result)
    );

    // Pixel transfer on the input side
    assign pixel_fire = stream.valid && stream.ready
                     && (stream.payload.mode == rabs_pkg::MODE_PIXEL);

    // A pixel transfer never lands on a word still in flight
    `RABS_ASSERT_IMPLY(a_no_hazard_transfer, pixel_fire, !status.conflict)

    // The pipeline is only issued from an accepted pixel
    `RABS_ASSERT_IMPLY(a_issue_from_pixel, issue.valid, pixel_fire)

    // The pipeline only fills up behind a stalled result
    `RABS_ASSERT_ALWAYS(a_full_only_on_stall, status.space || (result.valid && !result.ready))

endmodule

// ===== design/rabs_regs.sv =====
module rabs_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rabs_pkg::rabs_cfg_t cfg
);

    rabs_pkg::rabs_cfg_t cfg_reg;
    rabs_pkg::rabs_cfg_t cfg_next;
    logic [1:0]          reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Decode the write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rabs_pkg::REG_LEARN_RATE:     cfg_next.learn_rate        = pwdata[9:0];
                rabs_pkg::REG_TRACK_DARK:     cfg_next.track_dark        = pwdata[0];
                rabs_pkg::REG_RELEARN_PERIOD: cfg_next.relearn_period_ms = pwdata[14:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate        <= rabs_pkg::LEARN_RATE_RST;
            cfg_reg.track_dark        <= 1'b0;
            cfg_reg.relearn_period_ms <= rabs_pkg::PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            rabs_pkg::REG_LEARN_RATE:     prdata = 32'(cfg_reg.learn_rate);
            rabs_pkg::REG_TRACK_DARK:     prdata = 32'(cfg_reg.track_dark);
            rabs_pkg::REG_RELEARN_PERIOD: prdata = 32'(cfg_reg.relearn_period_ms);
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/rabs_ctrl.sv =====
module rabs_ctrl #(
    parameter int FRAME_PIXELS = 65536,
    parameter int ADDR_W       = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rabs_stream_if.sink                 stream,
    input  rabs_pkg::rabs_cfg_t         cfg,
    input  rabs_pkg::rabs_pipe_status_t status,
    output rabs_pkg::rabs_issue_t       issue,
    output logic [ADDR_W-1:0]           slot_pos
);

    localparam logic [ADDR_W:0] FRAME_LIMIT = (ADDR_W+1)'(FRAME_PIXELS);

    logic [14:0]       elapsed_reg, elapsed_next;
    logic              pending_reg, pending_next;
    logic              learning_reg, learning_next;
    logic              bvalid_reg, bvalid_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;

    logic              is_pixel;
    logic              start;
    logic              relearn;
    logic              learn_eff;
    logic              bvalid_eff;
    logic              fire;
    logic [ADDR_W:0]   pos_inc;

    assign is_pixel = (stream.payload.mode == rabs_pkg::MODE_PIXEL);
    assign start    = stream.payload.frame_start;
    assign relearn  = pending_reg || (elapsed_reg > cfg.relearn_period_ms);

    // Position and learn decision as this pixel sees them
    assign slot_pos   = start ? '0 : pos_reg;
    assign learn_eff  = start ? relearn : learning_reg;
    assign bvalid_eff = bvalid_reg || (start && relearn);
    assign pos_inc    = {1'b0, slot_pos} + (ADDR_W+1)'(1);

    // Hold a pixel whose background word is still in flight
    assign stream.ready = status.space && !(is_pixel && status.conflict);
    assign fire         = stream.valid && stream.ready;

    // Hand the pixel to the update pipeline once a background exists
    assign issue.valid = fire && is_pixel && bvalid_eff;
    assign issue.learn = learn_eff;
    assign issue.pixel = stream.payload.pixel;

    // Advance frame state on each transfer
    always_comb
    begin
        elapsed_next  = elapsed_reg;
        pending_next  = pending_reg;
        learning_next = learning_reg;
        bvalid_next   = bvalid_reg;
        pos_next      = pos_reg;
        if (fire)
        begin
            unique case (stream.payload.mode)
                rabs_pkg::MODE_TICK:
                begin
                    if (elapsed_reg != rabs_pkg::ELAPSED_MAX)
                        elapsed_next = elapsed_reg + 15'd1;
                end
                rabs_pkg::MODE_LEARN:
                begin
                    pending_next = 1'b1;
                end
                rabs_pkg::MODE_PIXEL:
                begin
                    if (start)
                    begin
                        learning_next = relearn;
                        if (relearn)
                        begin
                            pending_next = 1'b0;
                            elapsed_next = '0;
                            bvalid_next  = 1'b1;
                        end
                    end
                    pos_next = (pos_inc >= FRAME_LIMIT) ? '0 : pos_inc[ADDR_W-1:0];
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            pending_reg  <= 1'b0;
            learning_reg <= 1'b0;
            bvalid_reg   <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            elapsed_reg  <= elapsed_next;
            pending_reg  <= pending_next;
            learning_reg <= learning_next;
            bvalid_reg   <= bvalid_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ===== design/rabs_datapath.sv =====
module rabs_datapath #(
    parameter int FRAME_PIXELS = 65536,
    parameter int ADDR_W       = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rabs_pkg::rabs_cfg_t         cfg,
    input  rabs_pkg::rabs_issue_t       issue,
    input  logic [ADDR_W-1:0]           slot_pos,
    output rabs_pkg::rabs_pipe_status_t status,
    rabs_stream_if.source               result
);

    localparam int QM_W = rabs_pkg::NUM_W + rabs_pkg::RECIP1000_W;

    // Background store, one word per pixel position
    logic [15:0] bg_mem [FRAME_PIXELS];
    logic [15:0] rd_data_reg;

    // Stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, v4_next, out_valid_next;
    logic en2, en3, en4, en_out, space;

    // Stage payloads
    logic [ADDR_W-1:0]          pos1_reg, pos2_reg, pos3_reg;
    logic [7:0]                 pix1_reg, pix2_reg, pix3_reg, pix4_reg;
    logic                       learn1_reg, learn2_reg, learn3_reg, learn4_reg;
    logic [25:0]                p_new2_reg, p_old2_reg;
    logic [25:0]                num3_reg;
    logic [15:0]                q3_reg;
    logic [15:0]                bg4_reg;
    rabs_pkg::rabs_out_t        out_reg;

    logic [9:0]                 rate;
    logic [9:0]                 keep;
    logic [25:0]                p_new_next, p_old_next;
    logic [25:0]                num_next;
    logic [QM_W-1:0]            qm;
    logic [15:0]                q_next;
    logic [25:0]                rem;
    logic [15:0]                bg_new;
    logic [16:0]                bg_biased;
    logic [32:0]                bg8_prod;
    logic [7:0]                 bg8;
    rabs_pkg::rabs_out_t        out_next;

    // Pipeline advance: a stage moves when it is empty or the next one moves
    assign en_out = !out_valid_reg || result.ready;
    assign en4    = !v4_reg || en_out;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign space  = !v1_reg || en2;

    // Interlock on a word still being updated in the first three stages
    assign status.space    = space;
    assign status.conflict = (v1_reg && (pos1_reg == slot_pos))
                          || (v2_reg && (pos2_reg == slot_pos))
                          || (v3_reg && (pos3_reg == slot_pos));

    assign v1_next        = space  ? issue.valid : v1_reg;
    assign v2_next        = en2    ? v1_reg      : v2_reg;
    assign v3_next        = en3    ? v2_reg      : v3_reg;
    assign v4_next        = en4    ? v3_reg      : v4_reg;
    assign out_valid_next = en_out ? v4_reg      : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1: weight new pixel and old background
    assign rate       = (cfg.learn_rate > rabs_pkg::RATE_FULL) ? rabs_pkg::RATE_FULL
                                                               : cfg.learn_rate;
    assign keep       = rabs_pkg::RATE_FULL - rate;
    assign p_new_next = 26'(rate) * 26'({pix1_reg, pix1_reg});
    assign p_old_next = 26'(keep) * 26'(rd_data_reg);

    // Stage 2: round and scale by the reciprocal of 1000
    assign num_next = p_new2_reg + p_old2_reg + rabs_pkg::ROUND_HALF;
    assign qm       = QM_W'(num_next) * QM_W'(rabs_pkg::DIV1000_MUL);
    assign q_next   = qm[rabs_pkg::DIV1000_SHIFT +: 16];

    // Stage 3: correct the quotient; a learn frame takes the pixel itself
    assign rem    = num3_reg - (26'(q3_reg) * 26'(rabs_pkg::RATE_FULL));
    assign bg_new = learn3_reg ? {pix3_reg, pix3_reg}
                               : (q3_reg + 16'(rem >= 26'(rabs_pkg::RATE_FULL)));

    // Stage 4: 8-bit background and saturating difference
    assign bg_biased = 17'(bg4_reg) + rabs_pkg::BG8_BIAS;
    assign bg8_prod  = 33'(bg_biased) * 33'(rabs_pkg::DIV257_MUL);
    assign bg8       = bg8_prod[rabs_pkg::DIV257_SHIFT +: 8];

    always_comb
    begin
        out_next.learned_frame = learn4_reg;
        if (cfg.track_dark)
            out_next.difference = (bg8 > pix4_reg) ? (bg8 - pix4_reg) : 8'd0;
        else
            out_next.difference = (pix4_reg > bg8) ? (pix4_reg - bg8) : 8'd0;
    end

    // Read at issue, write back as stage 3 moves on
    always_ff @(posedge clk)
    begin
        if (v3_reg && en4)
            bg_mem[pos3_reg] <= bg_new;
        if (issue.valid)
            rd_data_reg <= bg_mem[slot_pos];
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            pos1_reg   <= slot_pos;
            pix1_reg   <= issue.pixel;
            learn1_reg <= issue.learn;
        end
        if (en2)
        begin
            pos2_reg   <= pos1_reg;
            pix2_reg   <= pix1_reg;
            learn2_reg <= learn1_reg;
            p_new2_reg <= p_new_next;
            p_old2_reg <= p_old_next;
        end
        if (en3)
        begin
            pos3_reg   <= pos2_reg;
            pix3_reg   <= pix2_reg;
            learn3_reg <= learn2_reg;
            num3_reg   <= num_next;
            q3_reg     <= q_next;
        end
        if (en4)
        begin
            pix4_reg   <= pix3_reg;
            learn4_reg <= learn3_reg;
            bg4_reg    <= bg_new;
        end
        if (en_out)
            out_reg <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int         FRAME_WORDS   = 65536;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         TICK_BURST    = 20;

    // Predicts the difference stream and holds the differences still owed by the block
    class background_tracker;
        bit [15:0]           bg_mem [FRAME_WORDS];
        bit                  bg_valid;
        bit [14:0]           elapsed;
        bit                  learn_req;
        bit                  learning;
        int                  next_pos;
        int                  written_extent;
        bit [9:0]            rate_cfg;
        bit                  dark_cfg;
        bit [14:0]           period_cfg;
        rabs_pkg::rabs_out_t diff_expected [$];
        int                  errors;

        function new();
            rate_cfg   = rabs_pkg::LEARN_RATE_RST;
            period_cfg = rabs_pkg::PERIOD_RST;
        endfunction

        function void set_reg(rabs_pkg::rabs_reg_t idx, logic [31:0] val);
            case (idx)
                rabs_pkg::REG_LEARN_RATE:     rate_cfg = val[9:0];
                rabs_pkg::REG_TRACK_DARK:     dark_cfg = val[0];
                rabs_pkg::REG_RELEARN_PERIOD: period_cfg = val[14:0];
                default: ;
            endcase
        endfunction

        function bit learns_at_start();
            return learn_req || (elapsed > period_cfg);
        endfunction

        // A pixel may not read a background word that no learn frame has written
        function bit safe_pixel(bit start);
            bit relearn;
            int pos;
            relearn = start ? learns_at_start() : learning;
            pos     = start ? 0 : next_pos;
            return relearn || !bg_valid || (pos < written_extent);
        endfunction

        function void take_item(rabs_pkg::rabs_in_t it);
            int                  pos;
            int                  rate;
            int                  full;
            int                  pix;
            int                  bg;
            int                  bg8;
            int                  diff;
            rabs_pkg::rabs_out_t res;
            pix  = int'(it.pixel);
            full = int'(rabs_pkg::RATE_FULL);
            case (it.mode)
                rabs_pkg::MODE_TICK:
                begin
                    if (elapsed != rabs_pkg::ELAPSED_MAX)
                        elapsed++;
                end
                rabs_pkg::MODE_LEARN:
                    learn_req = 1'b1;
                rabs_pkg::MODE_PIXEL:
                begin
                    // Decide on relearning at the frame boundary
                    if (it.frame_start)
                    begin
                        next_pos = 0;
                        if (learns_at_start())
                        begin
                            learning  = 1'b1;
                            learn_req = 1'b0;
                            elapsed   = '0;
                            bg_valid  = 1'b1;
                        end
                        else
                            learning = 1'b0;
                    end
                    pos      = next_pos;
                    next_pos = (pos + 1 >= FRAME_WORDS) ? 0 : pos + 1;
                    if (bg_valid)
                    begin
                        if (learning)
                        begin
                            bg_mem[pos] = 16'(pix * 257);
                            if (pos >= written_extent)
                                written_extent = pos + 1;
                        end
                        // Blend the pixel into the background, rounding half up
                        rate = (rate_cfg > rabs_pkg::RATE_FULL) ? full : int'(rate_cfg);
                        bg = (rate * pix * 257 + (full - rate) * int'(bg_mem[pos])
                              + int'(rabs_pkg::ROUND_HALF)) / full;
                        bg_mem[pos] = 16'(bg);
                        bg8 = (2 * bg + 257) / 514;
                        if (dark_cfg)
                            diff = (bg8 > pix) ? bg8 - pix : 0;
                        else
                            diff = (pix > bg8) ? pix - bg8 : 0;
                        res.difference    = diff[7:0];
                        res.learned_frame = learning;
                        diff_expected.push_back(res);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(rabs_pkg::rabs_out_t got);
            rabs_pkg::rabs_out_t want;
            if (diff_expected.size() == 0)
            begin
                $error("unexpected result: difference %0d learned_frame %0d",
                       got.difference, got.learned_frame);
                errors++;
                return;
            end
            want = diff_expected.pop_front();
            if (got.difference !== want.difference)
            begin
                $error("difference: expected %0d, actual %0d", want.difference, got.difference);
                errors++;
            end
            if (got.learned_frame !== want.learned_frame)
            begin
                $error("learned_frame: expected %0d, actual %0d",
                       want.learned_frame, got.learned_frame);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          tx_quiet;
    bit          rx_quiet;

    background_tracker tracker;

    rabs_stream_if #(.payload_t(rabs_pkg::rabs_in_t))  in_if ();
    rabs_stream_if #(.payload_t(rabs_pkg::rabs_out_t)) out_if ();

    running_average_background_subtract #(
        .FRAME_PIXELS(FRAME_WORDS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (in_if),
        .result  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 8'h00;
        if (r < 10)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Switch between stretches with and without idling
    always
    begin
        repeat (200) @(posedge clk);
        tx_quiet = ($urandom_range(3) == 0);
        rx_quiet = ($urandom_range(3) == 0);
    end

    // Stall the result side at random
    initial
    begin
        int stall;
        stall        = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_if.ready = 1'b0;
                stall--;
            end
            else
            begin
                out_if.ready = 1'b1;
                if (!rx_quiet && $urandom_range(99) < 15)
                    stall = idle_len();
            end
        end
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            tracker.check_result(out_if.payload);
    end

    task automatic send_raw(logic [1:0] mode, logic [7:0] pix, bit start, bit no_gap);
        rabs_pkg::rabs_in_t it;
        int                 gap;
        it.mode        = mode;
        it.pixel       = pix;
        it.frame_start = start;
        gap = 0;
        if (!no_gap && !tx_quiet && $urandom_range(99) < 20)
            gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_if.valid   = 1'b1;
        in_if.payload = it;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        tracker.take_item(it);
    endtask

    // Cut a frame short rather than read a word no learn frame wrote
    task automatic send_pixel(logic [7:0] pix, bit start, bit no_gap);
        bit first;
        first = start;
        if (!tracker.safe_pixel(first))
            first = 1'b1;
        send_raw(rabs_pkg::MODE_PIXEL, pix, first, no_gap);
    endtask

    // Hold off until every owed difference has come back and the pipe is empty
    task automatic settle();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (tracker.diff_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(rabs_pkg::rabs_reg_t idx, logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_reg(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic int frame_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(1, 8);
        if (r < 92)
            return $urandom_range(9, 40);
        return $urandom_range(100, 300);
    endfunction

    // Mostly whole frames with ticks and learn requests between them, plus noise
    task automatic random_traffic(int n_items);
        int done;
        int kind;
        int len;
        int k;
        done = 0;
        while (done < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 65)
            begin
                len = frame_len();
                for (k = 0; k < len; k++)
                    send_pixel(rand_pixel(), k == 0, 1'b0);
                done += len;
            end
            else if (kind < 80)
            begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    send_raw(rabs_pkg::MODE_TICK, rand_pixel(), 1'($urandom_range(1)), 1'b0);
                done += len;
            end
            else if (kind < 86)
            begin
                send_raw(rabs_pkg::MODE_LEARN, rand_pixel(), 1'($urandom_range(1)), 1'b0);
                done++;
            end
            else if (kind < 92)
                send_raw(MODE_UNUSED, rand_pixel(), 1'($urandom_range(1)), 1'b0);
            else if (kind < 99)
            begin
                send_pixel(rand_pixel(), 1'($urandom_range(1)), 1'b0);
                done++;
            end
            else
                settle();
        end
    endtask

    task automatic run_phase(logic [31:0] rate, logic [31:0] dark, logic [31:0] period,
                             int n_items);
        settle();
        write_reg(rabs_pkg::REG_LEARN_RATE, rate);
        write_reg(rabs_pkg::REG_TRACK_DARK, dark);
        write_reg(rabs_pkg::REG_RELEARN_PERIOD, period);
        random_traffic(n_items);
    endtask

    initial
    begin
        int p;
        int k;
        tracker       = new();
        rst_n         = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // No frame start and no background yet: nothing comes out
        send_pixel(8'h00, 1'b0, 1'b0);
        send_raw(rabs_pkg::MODE_TICK, 8'hFF, 1'b1, 1'b0);
        send_raw(MODE_UNUSED, 8'hA5, 1'b1, 1'b0);
        send_raw(rabs_pkg::MODE_LEARN, 8'h5A, 1'b0, 1'b0);
        // Learn frame of four pixels, then a tracking frame over the same words
        send_pixel(8'hFF, 1'b1, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h80, 1'b0, 1'b0);
        send_pixel(8'h01, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h7F, 1'b0, 1'b0);
        send_pixel(8'hC8, 1'b0, 1'b0);
        // Back-to-back one-pixel frames
        send_pixel(8'h10, 1'b1, 1'b1);
        send_pixel(8'hEF, 1'b1, 1'b1);
        // Dark mode with a rate above full scale
        settle();
        write_reg(rabs_pkg::REG_TRACK_DARK, 32'd1);
        write_reg(rabs_pkg::REG_LEARN_RATE, 32'd1023);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'hFF, 1'b0, 1'b0);
        send_pixel(8'h03, 1'b0, 1'b0);
        // Zero rate and zero period: one tick forces a relearn
        settle();
        write_reg(rabs_pkg::REG_LEARN_RATE, 32'd0);
        write_reg(rabs_pkg::REG_RELEARN_PERIOD, 32'd0);
        send_raw(rabs_pkg::MODE_TICK, 8'h00, 1'b0, 1'b0);
        send_pixel(8'hC8, 1'b1, 1'b0);
        send_pixel(8'h09, 1'b0, 1'b0);
        send_pixel(8'h32, 1'b1, 1'b0);

        // Random traffic over several settings, extremes first
        run_phase(32'd1000, 32'd0, 32'd20000, 250);
        run_phase(32'd0, 32'd1, 32'd0, 250);
        run_phase(32'd1023, 32'd0, 32'd32767, 200);
        for (p = 0; p < 5; p++)
            run_phase($urandom_range(1023), $urandom_range(1), $urandom_range(40), 210);

        // A burst of ticks under the top period keeps tracking; one below the count relearns
        settle();
        write_reg(rabs_pkg::REG_RELEARN_PERIOD, 32'd32767);
        write_reg(rabs_pkg::REG_LEARN_RATE, 32'd400);
        write_reg(rabs_pkg::REG_TRACK_DARK, 32'd0);
        send_pixel(8'h40, 1'b1, 1'b0);
        for (k = 0; k < TICK_BURST; k++)
            send_raw(rabs_pkg::MODE_TICK, 8'h00, 1'b0, 1'b1);
        send_pixel(8'h41, 1'b1, 1'b0);
        settle();
        write_reg(rabs_pkg::REG_RELEARN_PERIOD, 32'(TICK_BURST - 1));
        send_pixel(8'h42, 1'b1, 1'b0);
        send_pixel(8'h43, 1'b0, 1'b0);

        settle();
        if (tracker.errors == 0 && tracker.diff_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
